FILE: hw/rtl/nsl3d_pkg.sv
// ----------------------------------------------------------------------------
// nsl3d_pkg
// Shared types and codes for the 3D nearest seed locator.
// ----------------------------------------------------------------------------
`default_nettype none

package nsl3d_pkg;

    localparam int LANES     = 4;
    localparam int LANE_BITS = 2;

    typedef enum logic [1:0] {
        MODE_ADD    = 2'd0,
        MODE_LOCATE = 2'd1,
        MODE_DIST   = 2'd2,
        MODE_CLEAR  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_BADKEY = 2'd2,
        ST_EMPTY  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE  = 2'd0,
        S_SCAN  = 2'd1,
        S_DRAIN = 2'd2
    } state_t;

    // scan step marker travelling along the chain
    typedef struct packed {
        logic act;
        logic last;
    } tok_t;

endpackage

`default_nettype wire

FILE: hw/rtl/nsl3d_cell.sv
// ----------------------------------------------------------------------------
// nsl3d_cell
// One lane of the scan chain: a bank of seeds, a distance pipeline and a
// compare against the best candidate handed over by the previous lane.
// ----------------------------------------------------------------------------
`default_nettype none

module nsl3d_cell #(
    parameter int LANE  = 0,
    parameter int DEPTH = 256,
    parameter int AW    = 8,
    parameter int CB    = 16,
    parameter int CW    = 11,
    parameter int DW    = 36,
    parameter int IXW   = AW + nsl3d_pkg::LANE_BITS
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                wr_en,
    input  wire logic [nsl3d_pkg::LANE_BITS-1:0]     wr_lane,
    input  wire logic [AW-1:0]                       wr_addr,
    input  wire logic [3*CB-1:0]                     wr_data,
    input  wire logic [CB-1:0]                       qx,
    input  wire logic [CB-1:0]                       qy,
    input  wire logic [CB-1:0]                       qz,
    input  wire logic                                single,
    input  wire logic [IXW-1:0]                      key_ix,
    input  wire logic [CW-1:0]                       count,
    input  wire nsl3d_pkg::tok_t                     tok_in,
    input  wire logic [AW-1:0]                       addr_in,
    input  wire logic                                best_hit_in,
    input  wire logic [DW-1:0]                       best_dist_in,
    input  wire logic [IXW-1:0]                      best_idx_in,
    output nsl3d_pkg::tok_t                          tok_out,
    output logic [AW-1:0]                            addr_out,
    output nsl3d_pkg::tok_t                          best_tok,
    output logic                                     best_hit,
    output logic [DW-1:0]                            best_dist,
    output logic [IXW-1:0]                           best_idx
);

    localparam int CMPW = (CW > IXW) ? CW : IXW;

    logic [3*CB-1:0] mem [DEPTH];

    nsl3d_pkg::tok_t tok0_reg, tok1_reg, tok2_reg, tok3_reg, tok4_reg, btok_reg;
    logic            ok4_reg, bhit_reg;
    logic [AW-1:0]   addr0_reg;
    logic [IXW-1:0]  idx1_reg, idx2_reg, idx3_reg, idx4_reg, bidx_reg;
    logic [3*CB-1:0] rd_reg;
    logic [CB:0]     ax_reg, ay_reg, az_reg;
    logic [2*CB+1:0] sx_reg, sy_reg, sz_reg;
    logic [DW-1:0]   sum_reg, bdist_reg;

    logic            ok3;
    logic            take;

    function automatic logic [CB:0] absdiff(input logic [CB-1:0] a, input logic [CB-1:0] b);
        logic [CB:0] d;
        d = {a[CB-1], a} - {b[CB-1], b};
        return d[CB] ? (~d + 1'b1) : d;
    endfunction

    assign ok3  = single ? (idx3_reg == key_ix) : (CMPW'(idx3_reg) < CMPW'(count));
    assign take = tok4_reg.act && ok4_reg && (!best_hit_in || (sum_reg < best_dist_in));

    always_ff @(posedge clk)
    begin
        if (wr_en && (wr_lane == nsl3d_pkg::LANE_BITS'(LANE)))
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_reg <= mem[addr0_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok0_reg <= '0;
            tok1_reg <= '0;
            tok2_reg <= '0;
            tok3_reg <= '0;
            tok4_reg <= '0;
            btok_reg <= '0;
            ok4_reg  <= 1'b0;
            bhit_reg <= 1'b0;
        end
        else
        begin
            tok0_reg <= tok_in;
            tok1_reg <= tok0_reg;
            tok2_reg <= tok1_reg;
            tok3_reg <= tok2_reg;
            tok4_reg <= tok3_reg;
            btok_reg <= tok4_reg;
            ok4_reg  <= ok3;
            bhit_reg <= take || best_hit_in;
        end
    end

    always_ff @(posedge clk)
    begin
        addr0_reg <= addr_in;
        idx1_reg  <= {addr0_reg, nsl3d_pkg::LANE_BITS'(LANE)};
        idx2_reg  <= idx1_reg;
        ax_reg    <= absdiff(rd_reg[3*CB-1:2*CB], qx);
        ay_reg    <= absdiff(rd_reg[2*CB-1:CB], qy);
        az_reg    <= absdiff(rd_reg[CB-1:0], qz);
        idx3_reg  <= idx2_reg;
        sx_reg    <= ax_reg * ax_reg;
        sy_reg    <= ay_reg * ay_reg;
        sz_reg    <= az_reg * az_reg;
        idx4_reg  <= idx3_reg;
        sum_reg   <= DW'(sx_reg) + DW'(sy_reg) + DW'(sz_reg);
        bdist_reg <= take ? sum_reg : best_dist_in;
        bidx_reg  <= take ? idx4_reg : best_idx_in;
    end

    assign tok_out   = tok0_reg;
    assign addr_out  = addr0_reg;
    assign best_tok  = btok_reg;
    assign best_hit  = bhit_reg;
    assign best_dist = bdist_reg;
    assign best_idx  = bidx_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/nearest_seed_locator_3d_top.sv
// ----------------------------------------------------------------------------
// nearest_seed_locator_3d_top
// Seed table with add, clear, nearest-seed locate and distance-to-seed items.
// ----------------------------------------------------------------------------
// An item is taken on a clock edge with start high and busy low. Each item
// gives one result, shown for one cycle with done high; the receiver cannot
// stall it.
// Add and clear, and any item that is rejected (table full, bad key, empty
// table), give their result in the next cycle and leave busy low, so such
// items may follow every cycle.
// Locate and distance run on a chain of four lanes, each holding every
// fourth seed. The sequencer issues one step (four seeds) per cycle, so a
// locate scans ceil(count/4) steps and a distance query a single step;
// busy stays high until the result is given.
// Reset empties the table; seed storage itself is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module nearest_seed_locator_3d_top #(
    parameter int MAX_SEEDS  = 1024,
    parameter int COORD_BITS = 16
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic [1:0]            mode,
    input  wire logic [COORD_BITS-1:0] coord_x,
    input  wire logic [COORD_BITS-1:0] coord_y,
    input  wire logic [COORD_BITS-1:0] coord_z,
    input  wire logic [9:0]            seed_key,
    output logic                       done,
    output logic [9:0]                 seed_index,
    output logic [33:0]                sq_distance,
    output logic [10:0]                seed_count,
    output logic [1:0]                 status
);

    localparam int LANES = nsl3d_pkg::LANES;
    localparam int LB    = nsl3d_pkg::LANE_BITS;
    localparam int DEPTH = (MAX_SEEDS + LANES - 1) / LANES;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int IXW   = AW + LB;
    localparam int CW    = $clog2(MAX_SEEDS + 1);
    localparam int CB    = COORD_BITS;
    localparam int DW    = 2 * CB + 4;
    localparam int KCW   = (CW > 10) ? CW : 10;

    nsl3d_pkg::state_t state_reg, state_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [AW-1:0]   step_reg, step_next, last_step_reg, last_step_next;
    logic            single_reg, single_next;
    logic [IXW-1:0]  key_reg, key_next;
    logic [CB-1:0]   qx_reg, qx_next, qy_reg, qy_next, qz_reg, qz_next;
    logic            acc_hit_reg, acc_hit_next;
    logic [DW-1:0]   acc_dist_reg, acc_dist_next;
    logic [IXW-1:0]  acc_idx_reg, acc_idx_next;
    logic            done_reg, done_next;
    logic [9:0]      idx_out_reg, idx_out_next;
    logic [33:0]     dist_out_reg, dist_out_next;
    nsl3d_pkg::status_t status_reg, status_next;

    logic            accept;
    logic            wr_en;
    logic [CW-1:0]   cnt_m1;
    nsl3d_pkg::tok_t issue;
    logic            fin_take;
    logic            fin_hit;
    logic [DW-1:0]   fin_dist;
    logic [IXW-1:0]  fin_idx;

    nsl3d_pkg::tok_t tok_c   [LANES];
    logic [AW-1:0]   addr_c  [LANES];
    nsl3d_pkg::tok_t btok_c  [LANES];
    logic            hit_c   [LANES];
    logic [DW-1:0]   dist_c  [LANES];
    logic [IXW-1:0]  idx_c   [LANES];

    assign accept = start && (state_reg == nsl3d_pkg::S_IDLE);
    assign wr_en  = accept && (nsl3d_pkg::mode_t'(mode) == nsl3d_pkg::MODE_ADD)
                    && (count_reg < CW'(MAX_SEEDS));
    assign cnt_m1 = count_reg - CW'(1);

    assign issue.act  = (state_reg == nsl3d_pkg::S_SCAN);
    assign issue.last = (step_reg == last_step_reg);

    genvar k;
    generate
        for (k = 0; k < LANES; k++)
        begin : g_lane
            nsl3d_cell #(
                .LANE (k),
                .DEPTH(DEPTH),
                .AW   (AW),
                .CB   (CB),
                .CW   (CW),
                .DW   (DW),
                .IXW  (IXW)
            ) u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .wr_en       (wr_en),
                .wr_lane     (count_reg[LB-1:0]),
                .wr_addr     (AW'(count_reg >> LB)),
                .wr_data     ({coord_x, coord_y, coord_z}),
                .qx          (qx_reg),
                .qy          (qy_reg),
                .qz          (qz_reg),
                .single      (single_reg),
                .key_ix      (key_reg),
                .count       (count_reg),
                .tok_in      ((k == 0) ? issue : tok_c[(k == 0) ? 0 : k-1]),
                .addr_in     ((k == 0) ? step_reg : addr_c[(k == 0) ? 0 : k-1]),
                .best_hit_in ((k == 0) ? 1'b0 : hit_c[(k == 0) ? 0 : k-1]),
                .best_dist_in((k == 0) ? '0 : dist_c[(k == 0) ? 0 : k-1]),
                .best_idx_in ((k == 0) ? '0 : idx_c[(k == 0) ? 0 : k-1]),
                .tok_out     (tok_c[k]),
                .addr_out    (addr_c[k]),
                .best_tok    (btok_c[k]),
                .best_hit    (hit_c[k]),
                .best_dist   (dist_c[k]),
                .best_idx    (idx_c[k])
            );
        end
    endgenerate

    assign fin_take = hit_c[LANES-1] && (!acc_hit_reg || (dist_c[LANES-1] < acc_dist_reg));
    assign fin_hit  = fin_take || acc_hit_reg;
    assign fin_dist = fin_take ? dist_c[LANES-1] : acc_dist_reg;
    assign fin_idx  = fin_take ? idx_c[LANES-1] : acc_idx_reg;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        step_next      = step_reg;
        last_step_next = last_step_reg;
        single_next    = single_reg;
        key_next       = key_reg;
        qx_next        = qx_reg;
        qy_next        = qy_reg;
        qz_next        = qz_reg;
        acc_hit_next   = acc_hit_reg;
        acc_dist_next  = acc_dist_reg;
        acc_idx_next   = acc_idx_reg;
        done_next      = 1'b0;
        idx_out_next   = idx_out_reg;
        dist_out_next  = dist_out_reg;
        status_next    = status_reg;

        unique case (state_reg)
            nsl3d_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    idx_out_next  = '0;
                    dist_out_next = '0;
                    status_next   = nsl3d_pkg::ST_OK;
                    qx_next       = coord_x;
                    qy_next       = coord_y;
                    qz_next       = coord_z;
                    key_next      = IXW'(seed_key);
                    acc_hit_next  = 1'b0;
                    unique case (nsl3d_pkg::mode_t'(mode))
                        nsl3d_pkg::MODE_ADD:
                        begin
                            done_next = 1'b1;
                            if (wr_en)
                            begin
                                idx_out_next = 10'(count_reg);
                                count_next   = count_reg + CW'(1);
                            end
                            else
                            begin
                                status_next = nsl3d_pkg::ST_FULL;
                            end
                        end
                        nsl3d_pkg::MODE_LOCATE:
                        begin
                            if (count_reg == '0)
                            begin
                                done_next   = 1'b1;
                                status_next = nsl3d_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                single_next    = 1'b0;
                                step_next      = '0;
                                last_step_next = AW'(cnt_m1 >> LB);
                                state_next     = nsl3d_pkg::S_SCAN;
                            end
                        end
                        nsl3d_pkg::MODE_DIST:
                        begin
                            if (KCW'(seed_key) >= KCW'(count_reg))
                            begin
                                done_next    = 1'b1;
                                idx_out_next = seed_key;
                                status_next  = nsl3d_pkg::ST_BADKEY;
                            end
                            else
                            begin
                                single_next    = 1'b1;
                                step_next      = AW'(seed_key >> LB);
                                last_step_next = AW'(seed_key >> LB);
                                state_next     = nsl3d_pkg::S_SCAN;
                            end
                        end
                        nsl3d_pkg::MODE_CLEAR:
                        begin
                            done_next  = 1'b1;
                            count_next = '0;
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            nsl3d_pkg::S_SCAN:
            begin
                step_next = step_reg + AW'(1);
                if (issue.last)
                begin
                    state_next = nsl3d_pkg::S_DRAIN;
                end
            end
            nsl3d_pkg::S_DRAIN:
            begin
            end
            default:
            begin
                state_next = nsl3d_pkg::S_IDLE;
            end
        endcase

        if (btok_c[LANES-1].act)
        begin
            acc_hit_next  = fin_hit;
            acc_dist_next = fin_dist;
            acc_idx_next  = fin_idx;
            if (btok_c[LANES-1].last)
            begin
                done_next     = 1'b1;
                idx_out_next  = 10'(fin_idx);
                dist_out_next = 34'(fin_dist);
                status_next   = nsl3d_pkg::ST_OK;
                state_next    = nsl3d_pkg::S_IDLE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= nsl3d_pkg::S_IDLE;
            count_reg   <= '0;
            done_reg    <= 1'b0;
            acc_hit_reg <= 1'b0;
            status_reg  <= nsl3d_pkg::ST_OK;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            done_reg    <= done_next;
            acc_hit_reg <= acc_hit_next;
            status_reg  <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg      <= step_next;
        last_step_reg <= last_step_next;
        single_reg    <= single_next;
        key_reg       <= key_next;
        qx_reg        <= qx_next;
        qy_reg        <= qy_next;
        qz_reg        <= qz_next;
        acc_dist_reg  <= acc_dist_next;
        acc_idx_reg   <= acc_idx_next;
        idx_out_reg   <= idx_out_next;
        dist_out_reg  <= dist_out_next;
    end

    assign busy        = (state_reg != nsl3d_pkg::S_IDLE);
    assign done        = done_reg;
    assign seed_index  = idx_out_reg;
    assign sq_distance = dist_out_reg;
    assign seed_count  = 11'(count_reg);
    assign status      = status_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/nsl3d_checker.sv
// ----------------------------------------------------------------------------
// nsl3d_checker
// Port-level checks for the 3D nearest seed locator.
// ----------------------------------------------------------------------------
`default_nettype none

module nsl3d_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic        done,
    input wire logic [33:0] sq_distance,
    input wire logic [10:0] seed_count,
    input wire logic [1:0]  status
);

    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (done || busy))
        else $error("accepted item neither finished nor started a scan");

    a_no_done_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !(busy && done))
        else $error("result strobe while busy");

    a_scan_ends_in_result: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("scan ended without a result");

    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == nsl3d_pkg::ST_EMPTY)) |-> ((seed_count == '0) && (sq_distance == '0)))
        else $error("empty-table result with nonzero count or distance");

    a_badkey_result: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == nsl3d_pkg::ST_BADKEY)) |-> (sq_distance == '0))
        else $error("bad-key result with nonzero distance");

endmodule

bind nearest_seed_locator_3d_top nsl3d_checker u_nsl3d_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .done       (done),
    .sq_distance(sq_distance),
    .seed_count (seed_count),
    .status     (status)
);

`default_nettype wire

FILE: tb/nsl3d_checker.sv
// ----------------------------------------------------------------------------
// nsl3d_scoreboard
// Tracks the seed table, predicts each result and compares it on done.
// ----------------------------------------------------------------------------
// Every item taken (start high, busy low) is turned into an expected result
// from a local copy of the seed table. Each done pulse is compared field by
// field with the oldest expected result.
// ----------------------------------------------------------------------------
`default_nettype none

module nsl3d_scoreboard (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic        busy,
    input  wire logic [1:0]  mode,
    input  wire logic [15:0] coord_x,
    input  wire logic [15:0] coord_y,
    input  wire logic [15:0] coord_z,
    input  wire logic [9:0]  seed_key,
    input  wire logic        done,
    input  wire logic [9:0]  seed_index,
    input  wire logic [33:0] sq_distance,
    input  wire logic [10:0] seed_count,
    input  wire logic [1:0]  status,
    output int               fails,
    output int               pending,
    output int               results_seen
);

    localparam int TABLE_DEPTH = 1024;

    typedef struct {
        logic [9:0]           idx;
        logic [33:0]          sq;
        logic [10:0]          cnt;
        nsl3d_pkg::status_t   st;
    } seed_result_t;

    logic signed [15:0] tbl_x [TABLE_DEPTH];
    logic signed [15:0] tbl_y [TABLE_DEPTH];
    logic signed [15:0] tbl_z [TABLE_DEPTH];
    int                 tbl_count;
    seed_result_t       expected_q [$];

    function automatic longint sq_gap(logic signed [15:0] a, logic signed [15:0] b);
        longint d;
        d = longint'(a) - longint'(b);
        return d * d;
    endfunction

    function automatic longint seed_sq_dist(int i, logic signed [15:0] x,
                                            logic signed [15:0] y, logic signed [15:0] z);
        return sq_gap(tbl_x[i], x) + sq_gap(tbl_y[i], y) + sq_gap(tbl_z[i], z);
    endfunction

    function automatic seed_result_t predict_item(nsl3d_pkg::mode_t m,
                                                  logic signed [15:0] x,
                                                  logic signed [15:0] y,
                                                  logic signed [15:0] z, logic [9:0] key);
        seed_result_t r;
        longint       best;
        longint       d;
        r.idx = '0;
        r.sq  = '0;
        r.st  = nsl3d_pkg::ST_OK;
        case (m)
            nsl3d_pkg::MODE_ADD:
                if (tbl_count >= TABLE_DEPTH)
                    r.st = nsl3d_pkg::ST_FULL;
                else
                begin
                    tbl_x[tbl_count] = x;
                    tbl_y[tbl_count] = y;
                    tbl_z[tbl_count] = z;
                    r.idx = tbl_count[9:0];
                    tbl_count++;
                end
            nsl3d_pkg::MODE_LOCATE:
                if (tbl_count == 0)
                    r.st = nsl3d_pkg::ST_EMPTY;
                else
                begin
                    best = seed_sq_dist(0, x, y, z);
                    for (int i = 1; i < tbl_count; i++)
                    begin
                        d = seed_sq_dist(i, x, y, z);
                        if (d < best)
                        begin
                            best  = d;
                            r.idx = i[9:0];
                        end
                    end
                    r.sq = best[33:0];
                end
            nsl3d_pkg::MODE_DIST:
            begin
                r.idx = key;
                if (int'(key) >= tbl_count)
                    r.st = nsl3d_pkg::ST_BADKEY;
                else
                begin
                    d    = seed_sq_dist(int'(key), x, y, z);
                    r.sq = d[33:0];
                end
            end
            default:
                tbl_count = 0;
        endcase
        r.cnt = tbl_count[10:0];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        seed_result_t e;
        if (!rst_n)
        begin
            tbl_count = 0;
            expected_q.delete();
            fails        <= 0;
            results_seen <= 0;
            pending      <= 0;
        end
        else
        begin
            if (done)
            begin
                results_seen <= results_seen + 1;
                if (expected_q.size() == 0)
                begin
                    $display("%0t: result with nothing expected: idx %0d dist %0d cnt %0d st %0d",
                             $time, seed_index, sq_distance, seed_count, status);
                    fails <= fails + 1;
                end
                else
                begin
                    e = expected_q.pop_front();
                    if (seed_index !== e.idx || sq_distance !== e.sq ||
                        seed_count !== e.cnt || status !== e.st)
                        fails <= fails + 1;
                    if (seed_index !== e.idx)
                        $display("%0t: seed_index expected %0d actual %0d",
                                 $time, e.idx, seed_index);
                    if (sq_distance !== e.sq)
                        $display("%0t: sq_distance expected %0d actual %0d",
                                 $time, e.sq, sq_distance);
                    if (seed_count !== e.cnt)
                        $display("%0t: seed_count expected %0d actual %0d",
                                 $time, e.cnt, seed_count);
                    if (status !== e.st)
                        $display("%0t: status expected %0d actual %0d",
                                 $time, e.st, status);
                end
            end
            if (start && !busy)
                expected_q.insert(expected_q.size(),
                                  predict_item(nsl3d_pkg::mode_t'(mode), coord_x, coord_y,
                                               coord_z, seed_key));
            pending <= expected_q.size();
        end
    end

endmodule

`default_nettype wire

FILE: tb/tb_nearest_seed_locator_3d_top.sv
// ----------------------------------------------------------------------------
// tb_nearest_seed_locator_3d_top
// Item stimulus and verdict for the 3D nearest seed locator.
// ----------------------------------------------------------------------------
// Directed items hit empty and tie cases and coordinate extremes; then
// random episodes build tables of random size and query them with locate and
// distance items.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_nearest_seed_locator_3d_top;

    localparam int TABLE_DEPTH = 1024;
    localparam int STALL_LIMIT = 2000;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    nsl3d_pkg::mode_t  mode;
    logic [15:0]       coord_x;
    logic [15:0]       coord_y;
    logic [15:0]       coord_z;
    logic [9:0]        seed_key;
    logic              done;
    logic [9:0]        seed_index;
    logic [33:0]       sq_distance;
    logic [10:0]       seed_count;
    logic [1:0]        status;

    int fails;
    int pending;
    int results_seen;
    int idle_cycles;
    int shadow_count;
    int items_sent;
    int locates_sent;
    int dists_sent;
    bit no_gaps;

    nearest_seed_locator_3d_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .mode        (mode),
        .coord_x     (coord_x),
        .coord_y     (coord_y),
        .coord_z     (coord_z),
        .seed_key    (seed_key),
        .done        (done),
        .seed_index  (seed_index),
        .sq_distance (sq_distance),
        .seed_count  (seed_count),
        .status      (status)
    );

    nsl3d_scoreboard u_scoreboard (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .mode         (mode),
        .coord_x      (coord_x),
        .coord_y      (coord_y),
        .coord_z      (coord_z),
        .seed_key     (seed_key),
        .done         (done),
        .seed_index   (seed_index),
        .sq_distance  (sq_distance),
        .seed_count   (seed_count),
        .status       (status),
        .fails        (fails),
        .pending      (pending),
        .results_seen (results_seen)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("tb_nearest_seed_locator_3d_top failed");
            $finish;
        end
    end

    function automatic logic [15:0] pick_coord(int spread);
        case ($urandom_range(0, 9))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2, 3:    return 16'(int'($urandom_range(0, 2 * spread)) - spread);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_item(nsl3d_pkg::mode_t m, logic [15:0] x, logic [15:0] y,
                             logic [15:0] z, logic [9:0] key);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start    <= 1'b1;
        mode     <= m;
        coord_x  <= x;
        coord_y  <= y;
        coord_z  <= z;
        seed_key <= key;
        do
            @(posedge clk);
        while (busy);
        @(negedge clk);
        items_sent++;
        case (m)
            nsl3d_pkg::MODE_ADD:
                if (shadow_count < TABLE_DEPTH)
                    shadow_count++;
            nsl3d_pkg::MODE_LOCATE: locates_sent++;
            nsl3d_pkg::MODE_DIST:   dists_sent++;
            default:                shadow_count = 0;
        endcase
    endtask

    task automatic send_query(int spread);
        logic [9:0] key;
        if ($urandom_range(0, 1) == 0)
            send_item(nsl3d_pkg::MODE_LOCATE, pick_coord(spread), pick_coord(spread),
                      pick_coord(spread), 10'($urandom));
        else
        begin
            if (shadow_count > 0 && $urandom_range(0, 4) != 0)
                key = 10'($urandom_range(0, shadow_count - 1));
            else
                key = 10'($urandom);
            send_item(nsl3d_pkg::MODE_DIST, pick_coord(spread), pick_coord(spread),
                      pick_coord(spread), key);
        end
    endtask

    initial
    begin
        int n_seeds;
        int n_queries;
        int spread;
        rst_n        = 1'b0;
        start        = 1'b0;
        mode         = nsl3d_pkg::MODE_ADD;
        coord_x      = '0;
        coord_y      = '0;
        coord_z      = '0;
        seed_key     = '0;
        idle_cycles  = 0;
        shadow_count = 0;
        items_sent   = 0;
        locates_sent = 0;
        dists_sent   = 0;
        no_gaps      = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // empty table cases, then extremes and a tie
        send_item(nsl3d_pkg::MODE_LOCATE, 16'h0000, 16'h0000, 16'h0000, 10'd0);
        send_item(nsl3d_pkg::MODE_DIST, 16'h0001, 16'h0002, 16'h0003, 10'd0);
        send_item(nsl3d_pkg::MODE_CLEAR, 16'hFFFF, 16'hFFFF, 16'hFFFF, 10'h3FF);
        send_item(nsl3d_pkg::MODE_ADD, 16'h8000, 16'h8000, 16'h8000, 10'h3FF);
        send_item(nsl3d_pkg::MODE_ADD, 16'h7FFF, 16'h7FFF, 16'h7FFF, 10'd0);
        send_item(nsl3d_pkg::MODE_ADD, 16'h0000, 16'h0000, 16'h0000, 10'd0);
        send_item(nsl3d_pkg::MODE_ADD, 16'h0000, 16'h0000, 16'h0000, 10'd0);
        send_item(nsl3d_pkg::MODE_DIST, 16'h7FFF, 16'h7FFF, 16'h7FFF, 10'd0);
        send_item(nsl3d_pkg::MODE_DIST, 16'h8000, 16'h8000, 16'h8000, 10'd1);
        send_item(nsl3d_pkg::MODE_DIST, 16'h0000, 16'h0000, 16'h0000, 10'd4);
        send_item(nsl3d_pkg::MODE_DIST, 16'h0000, 16'h0000, 16'h0000, 10'h3FF);
        send_item(nsl3d_pkg::MODE_LOCATE, 16'h0000, 16'h0000, 16'h0000, 10'd0);
        send_item(nsl3d_pkg::MODE_LOCATE, 16'h7FFF, 16'h8000, 16'h7FFF, 10'd0);
        send_item(nsl3d_pkg::MODE_LOCATE, 16'h8001, 16'h8000, 16'h8000, 10'd0);
        send_item(nsl3d_pkg::MODE_LOCATE, 16'h0001, 16'hFFFF, 16'h0000, 10'd0);
        send_item(nsl3d_pkg::MODE_CLEAR, 16'h0000, 16'h0000, 16'h0000, 10'd0);
        send_item(nsl3d_pkg::MODE_LOCATE, 16'h1234, 16'h5678, 16'h9ABC, 10'd0);
        send_item(nsl3d_pkg::MODE_DIST, 16'h0000, 16'h0000, 16'h0000, 10'd0);
        send_item(nsl3d_pkg::MODE_ADD, 16'h5555, 16'hAAAA, 16'h5555, 10'h2AA);
        send_item(nsl3d_pkg::MODE_LOCATE, 16'hAAAA, 16'h5555, 16'hAAAA, 10'h155);

        // random episodes of table builds and queries
        while (items_sent < 850)
        begin
            no_gaps = ($urandom_range(0, 3) == 0);
            spread  = ($urandom_range(0, 1) == 0) ? 8 : 3000;
            if ($urandom_range(0, 2) != 0)
                send_item(nsl3d_pkg::MODE_CLEAR, 16'($urandom), 16'($urandom),
                          16'($urandom), 10'($urandom));
            n_seeds = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 40);
            repeat (n_seeds)
                if (shadow_count < 500)
                    send_item(nsl3d_pkg::MODE_ADD, pick_coord(spread), pick_coord(spread),
                              pick_coord(spread), 10'($urandom));
            n_queries = $urandom_range(10, 30);
            repeat (n_queries)
                case ($urandom_range(0, 19))
                    0:       send_item(nsl3d_pkg::MODE_CLEAR, 16'($urandom), 16'($urandom),
                                       16'($urandom), 10'($urandom));
                    1, 2:    send_item(nsl3d_pkg::MODE_ADD, pick_coord(spread),
                                       pick_coord(spread), pick_coord(spread),
                                       10'($urandom));
                    default: send_query(spread);
                endcase
        end
        start <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        $display("Sent %0d items (%0d locates, %0d distance queries),",
                 items_sent, locates_sent, dists_sent);
        $display("%0d results checked.", results_seen);
        if (fails == 0)
            $display("tb_nearest_seed_locator_3d_top passed");
        else
            $display("tb_nearest_seed_locator_3d_top failed");
        $finish;
    end

endmodule

`default_nettype wire
